/* src/fcis_pkg.sv */
// Package for the five-vertex clique / independent set search block.
// Holds the request and result structs, command and kind codes, defaults.
// No dependencies; the top level, checker and testbench refer to it by scoped names.
`timescale 1ns / 1ps

package fcis_pkg;

  // Graph size and search constants
  localparam int MAX_VERTICES_DEF = 64;
  localparam int SET_SIZE         = 5;
  localparam int VTX_W            = 7;
  localparam logic [VTX_W-1:0] VCOUNT_RESET = 7'd64;

  // Command codes
  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_SEARCH   = 1'b1;

  // Set kind codes
  localparam logic KIND_CLIQUE = 1'b0;
  localparam logic KIND_INDEP  = 1'b1;

  // Input request payload
  typedef struct packed {
    logic             command;
    logic [VTX_W-1:0] first_vertex;
    logic [VTX_W-1:0] second_vertex;
  } in_req_t;

  // Search result payload
  typedef struct packed {
    logic             found;
    logic             set_kind;
    logic [VTX_W-1:0] vertex_one;
    logic [VTX_W-1:0] vertex_two;
    logic [VTX_W-1:0] vertex_three;
    logic [VTX_W-1:0] vertex_four;
    logic [VTX_W-1:0] vertex_five;
  } out_rsp_t;

endpackage

/* src/fcis_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the adjacency rows of the search block; no dependencies.
`timescale 1ns / 1ps

module fcis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one row, read one row through a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/five_clique_or_independent_set_search.sv */
// Top level of the five-vertex clique / independent set search block.
// Depends on fcis_pkg (types, codes) and fcis_ram (adjacency row storage).
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+-----------------------------------
//  request  | start, busy, in_req          | taken when start=1 and busy=0
//  result   | out_strobe, out_rsp          | one-cycle strobe, cannot be held
//  config   | cfg_we, cfg_wdata            | vertex_count written when cfg_we=1
//
// An add-edge request keeps busy high through a read-modify-write of the
// first endpoint's row, then of the second, through the single RAM.
// A search walks candidate masks depth first: it scans one vertex or backs
// off at each step and reads a row on each descent, then gives the result;
// the longest searches come at 64 vertices on a dense graph with many
// four-cliques and no five-clique. The result strobe lands in the
// last busy cycle, while the per-row valid bits are dropped to clear the
// matrix; the receiver cannot stall it.
// Reset is synchronous, active low; the matrix reads as empty right after it.
`timescale 1ns / 1ps

module five_clique_or_independent_set_search #(
  parameter int MAX_VERTICES = fcis_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  fcis_pkg::in_req_t              in_req,
  output logic                           out_strobe,
  output fcis_pkg::out_rsp_t             out_rsp,
  input  logic                           cfg_we,
  input  logic [fcis_pkg::VTX_W-1:0]     cfg_wdata
);

  localparam int N  = MAX_VERTICES;
  localparam int AW = $clog2(N);
  localparam int PW = $clog2(N + 1);
  localparam int XW = AW + 8;
  localparam int SS = fcis_pkg::SET_SIZE;
  localparam int DW = $clog2(SS);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERDA = 3'd1;
  localparam logic [2:0] S_EWRA = 3'd2;
  localparam logic [2:0] S_ERDB = 3'd3;
  localparam logic [2:0] S_EWRB = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_ROW  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [AW-1:0]               a_idx_r, a_idx_nxt;
  logic [AW-1:0]               b_idx_r, b_idx_nxt;
  logic                        edge_ok_r, edge_ok_nxt;
  logic                        want_r, want_nxt;
  logic [DW-1:0]               depth_r, depth_nxt;
  logic [PW-1:0]               ptr_r [SS];
  logic [PW-1:0]               ptr_nxt [SS];
  logic [N-1:0]                cand_r [SS];
  logic [N-1:0]                cand_nxt [SS];
  logic [N-1:0]                row_vld_r, row_vld_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  fcis_pkg::out_rsp_t          out_rsp_r, out_rsp_nxt;
  logic [fcis_pkg::VTX_W-1:0]  vcount_r;

  logic                        accept;
  logic [XW-1:0]               a_ext, b_ext, a_m1, b_m1;
  logic                        a_ok, b_ok;
  logic [XW-1:0]               lim_x;
  logic [N-1:0]                init_mask;
  logic [PW-1:0]               cur_ptr;
  logic [AW-1:0]               p_idx;
  logic [N-1:0]                cur_cand;
  logic [N-1:0]                row_word;
  logic [N-1:0]                filt;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [N-1:0]                ram_wdata, ram_rdata;

  function automatic logic [fcis_pkg::VTX_W-1:0] to_vtx(input logic [PW-1:0] p);
    logic [XW-1:0] s;
    s = XW'(p) + XW'(1);
    return s[fcis_pkg::VTX_W-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Range-check and rebase the edge endpoints
  assign a_ext = XW'(in_req.first_vertex);
  assign b_ext = XW'(in_req.second_vertex);
  assign a_ok  = (a_ext != '0) && (a_ext <= XW'(N));
  assign b_ok  = (b_ext != '0) && (b_ext <= XW'(N));
  assign a_m1  = a_ext - XW'(1);
  assign b_m1  = b_ext - XW'(1);

  // Clamp the search range and build the first candidate mask
  assign lim_x = (XW'(vcount_r) > XW'(N)) ? XW'(N) : XW'(vcount_r);
  always_comb begin
    for (int i = 0; i < N; i++) begin
      init_mask[i] = (XW'(i) < lim_x);
    end
  end

  // Current search position
  assign cur_ptr  = ptr_r[depth_r];
  assign p_idx    = cur_ptr[AW-1:0];
  assign cur_cand = cand_r[depth_r];
  assign row_word = row_vld_r[p_idx] ? ram_rdata : '0;
  assign filt     = want_r ? row_word : ~row_word;

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_idx_r;
    ram_wdata = (row_vld_r[a_idx_r] ? ram_rdata : '0) | (N'(1) << b_idx_r);
    ram_raddr = p_idx;
    unique case (state_r)
      S_ERDA: ram_raddr = a_idx_r;
      S_ERDB: ram_raddr = b_idx_r;
      S_EWRA: ram_we    = edge_ok_r;
      S_EWRB: begin
        ram_we    = edge_ok_r;
        ram_waddr = b_idx_r;
        ram_wdata = (row_vld_r[b_idx_r] ? ram_rdata : '0) | (N'(1) << a_idx_r);
      end
      default: ;
    endcase
  end

  // Sequencer: edge read-modify-write, depth-first search, result
  always_comb begin
    state_nxt      = state_r;
    a_idx_nxt      = a_idx_r;
    b_idx_nxt      = b_idx_r;
    edge_ok_nxt    = edge_ok_r;
    want_nxt       = want_r;
    depth_nxt      = depth_r;
    ptr_nxt        = ptr_r;
    cand_nxt       = cand_r;
    row_vld_nxt    = row_vld_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.command == fcis_pkg::CMD_ADD_EDGE) begin
            a_idx_nxt   = a_m1[AW-1:0];
            b_idx_nxt   = b_m1[AW-1:0];
            edge_ok_nxt = a_ok && b_ok;
            state_nxt   = S_ERDA;
          end else begin
            want_nxt    = 1'b1;
            depth_nxt   = '0;
            ptr_nxt[0]  = '0;
            cand_nxt[0] = init_mask;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_ERDA: state_nxt = S_EWRA;
      S_EWRA: begin
        if (edge_ok_r) begin
          row_vld_nxt[a_idx_r] = 1'b1;
        end
        state_nxt = S_ERDB;
      end
      S_ERDB: state_nxt = S_EWRB;
      S_EWRB: begin
        if (edge_ok_r) begin
          row_vld_nxt[b_idx_r] = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (XW'(cur_ptr) >= lim_x) begin
          // Candidates at this depth exhausted: back off, switch kind or report no set
          if (depth_r == '0) begin
            if (want_r) begin
              want_nxt   = 1'b0;
              ptr_nxt[0] = '0;
            end else begin
              out_rsp_nxt    = '0;
              out_strobe_nxt = 1'b1;
              state_nxt      = S_DONE;
            end
          end else begin
            depth_nxt          = depth_r - DW'(1);
            ptr_nxt[depth_nxt] = ptr_r[depth_nxt] + PW'(1);
          end
        end else if (!cur_cand[p_idx]) begin
          ptr_nxt[depth_r] = cur_ptr + PW'(1);
        end else if (depth_r == DW'(SS - 1)) begin
          out_rsp_nxt.found        = 1'b1;
          out_rsp_nxt.set_kind     = want_r ? fcis_pkg::KIND_CLIQUE : fcis_pkg::KIND_INDEP;
          out_rsp_nxt.vertex_one   = to_vtx(ptr_r[0]);
          out_rsp_nxt.vertex_two   = to_vtx(ptr_r[1]);
          out_rsp_nxt.vertex_three = to_vtx(ptr_r[2]);
          out_rsp_nxt.vertex_four  = to_vtx(ptr_r[3]);
          out_rsp_nxt.vertex_five  = to_vtx(ptr_r[4]);
          out_strobe_nxt           = 1'b1;
          state_nxt                = S_DONE;
        end else begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        // Narrow the candidates to vertices compatible with the chosen one
        depth_nxt           = depth_r + DW'(1);
        cand_nxt[depth_nxt] = cur_cand & filt;
        ptr_nxt[depth_nxt]  = cur_ptr + PW'(1);
        state_nxt           = S_SCAN;
      end
      S_DONE: begin
        row_vld_nxt = '0;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_vld_r    <= '0;
      out_strobe_r <= 1'b0;
      vcount_r     <= fcis_pkg::VCOUNT_RESET;
      want_r       <= 1'b1;
      depth_r      <= '0;
      edge_ok_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_vld_r    <= row_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      want_r       <= want_nxt;
      depth_r      <= depth_nxt;
      edge_ok_r    <= edge_ok_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_idx_r   <= a_idx_nxt;
    b_idx_r   <= b_idx_nxt;
    ptr_r     <= ptr_nxt;
    cand_r    <= cand_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  fcis_ram #(
    .WIDTH (N),
    .DEPTH (N)
  ) u_adj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* src/fcis_checker.sv */
// Port-level checker for the five-vertex search block, bound to the top level.
// Depends on fcis_pkg for the request and result structs.
`timescale 1ns / 1ps

module fcis_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input fcis_pkg::in_req_t  in_req,
  input logic               out_strobe,
  input fcis_pkg::out_rsp_t out_rsp
);

  // An accepted request always occupies the block for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block idle right after accepting a request");

  // A result appears only in the last busy cycle of a search
  a_strobe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy ##1 (!busy && !out_strobe))
    else $error("result strobe outside the final busy cycle");

  // No result strobe in the last busy cycle of an edge load
  a_strobe_search: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.command == fcis_pkg::CMD_ADD_EDGE) |=> ##3 !out_strobe)
    else $error("result after an edge load");

  // A not-found result carries all zeros
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_rsp.found |->
      (out_rsp.set_kind == 1'b0) && (out_rsp.vertex_one == '0) &&
      (out_rsp.vertex_two == '0) && (out_rsp.vertex_three == '0) &&
      (out_rsp.vertex_four == '0) && (out_rsp.vertex_five == '0))
    else $error("not-found result with nonzero fields");

  // Found vertices are 1-based and strictly increasing
  a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_rsp.found |->
      (out_rsp.vertex_one != '0) &&
      (out_rsp.vertex_one < out_rsp.vertex_two) &&
      (out_rsp.vertex_two < out_rsp.vertex_three) &&
      (out_rsp.vertex_three < out_rsp.vertex_four) &&
      (out_rsp.vertex_four < out_rsp.vertex_five))
    else $error("found vertices out of order");

endmodule

bind five_clique_or_independent_set_search fcis_checker u_fcis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);

/* test/five_clique_or_independent_set_search_test.sv */
// Testbench for five_clique_or_independent_set_search: loads graphs one edge
// request at a time, runs searches, and checks each result against a local
// predictor of the adjacency matrix. Depends on fcis_pkg and the block only.
`timescale 1ns / 1ps

module five_clique_or_independent_set_search_test;

  localparam int MAX_V          = fcis_pkg::MAX_VERTICES_DEF;
  localparam int VW             = fcis_pkg::VTX_W;
  localparam int ITEM_TARGET    = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000000;
  localparam fcis_pkg::out_rsp_t NOT_FOUND = '0;

  typedef struct {
    logic               is_cfg;
    logic [VW-1:0]      cfg_value;
    fcis_pkg::in_req_t  req;
    logic               typed;
    fcis_pkg::out_rsp_t rsp;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  fcis_pkg::in_req_t  in_req;
  logic               out_strobe;
  fcis_pkg::out_rsp_t out_rsp;
  logic               cfg_we;
  logic [VW-1:0]      cfg_wdata;

  // Predictor state: adjacency rows, the vertex count register, expected results, plan
  logic [MAX_V-1:0]   link_rows [MAX_V];
  logic [VW-1:0]      count_q;
  fcis_pkg::out_rsp_t pending_sets [$];
  plan_row_t          directed_plan [$];

  int errors;
  int stall_cycles;
  int useful_items;
  int edges_stored;
  int edges_ignored;
  int cliques_seen;
  int indeps_seen;
  int misses_seen;

  five_clique_or_independent_set_search #(
    .MAX_VERTICES(MAX_V)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic bit vertex_ok(logic [VW-1:0] v);
    return (int'(v) >= 1) && (int'(v) <= MAX_V);
  endfunction

  // Find the first increasing five-tuple that is all linked, else all unlinked
  function automatic fcis_pkg::out_rsp_t search_graph();
    fcis_pkg::out_rsp_t rsp;
    int                 lim;
    logic               want;
    rsp = NOT_FOUND;
    lim = (int'(count_q) > MAX_V) ? MAX_V : int'(count_q);
    for (int pass = 0; pass < 2 && !rsp.found; pass++) begin
      want = (pass == 0) ? 1'b1 : 1'b0;
      for (int a = 0; a < lim && !rsp.found; a++)
        for (int b = a + 1; b < lim && !rsp.found; b++)
          if (link_rows[a][b] == want)
            for (int c = b + 1; c < lim && !rsp.found; c++)
              if (link_rows[a][c] == want && link_rows[b][c] == want)
                for (int d = c + 1; d < lim && !rsp.found; d++)
                  if (link_rows[a][d] == want && link_rows[b][d] == want &&
                      link_rows[c][d] == want)
                    for (int e = d + 1; e < lim && !rsp.found; e++)
                      if (link_rows[a][e] == want && link_rows[b][e] == want &&
                          link_rows[c][e] == want && link_rows[d][e] == want) begin
                        rsp.found        = 1'b1;
                        rsp.set_kind     = want ? fcis_pkg::KIND_CLIQUE
                                                : fcis_pkg::KIND_INDEP;
                        rsp.vertex_one   = VW'(a + 1);
                        rsp.vertex_two   = VW'(b + 1);
                        rsp.vertex_three = VW'(c + 1);
                        rsp.vertex_four  = VW'(d + 1);
                        rsp.vertex_five  = VW'(e + 1);
                      end
    end
    return rsp;
  endfunction

  function automatic fcis_pkg::out_rsp_t make_set(logic kind, int v1, int v2, int v3,
                                                   int v4, int v5);
    fcis_pkg::out_rsp_t rsp;
    rsp.found        = 1'b1;
    rsp.set_kind     = kind;
    rsp.vertex_one   = VW'(v1);
    rsp.vertex_two   = VW'(v2);
    rsp.vertex_three = VW'(v3);
    rsp.vertex_four  = VW'(v4);
    rsp.vertex_five  = VW'(v5);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic check_result(input fcis_pkg::out_rsp_t got);
    fcis_pkg::out_rsp_t want;
    if (pending_sets.size() == 0) begin
      report_mismatch("result with no search pending", int'(got.found), 0);
    end else begin
      want = pending_sets.pop_front();
      if (got.found != want.found)
        report_mismatch("found", int'(got.found), int'(want.found));
      if (got.set_kind != want.set_kind)
        report_mismatch("set_kind", int'(got.set_kind), int'(want.set_kind));
      if (got.vertex_one != want.vertex_one)
        report_mismatch("vertex_one", int'(got.vertex_one), int'(want.vertex_one));
      if (got.vertex_two != want.vertex_two)
        report_mismatch("vertex_two", int'(got.vertex_two), int'(want.vertex_two));
      if (got.vertex_three != want.vertex_three)
        report_mismatch("vertex_three", int'(got.vertex_three), int'(want.vertex_three));
      if (got.vertex_four != want.vertex_four)
        report_mismatch("vertex_four", int'(got.vertex_four), int'(want.vertex_four));
      if (got.vertex_five != want.vertex_five)
        report_mismatch("vertex_five", int'(got.vertex_five), int'(want.vertex_five));
    end
  endtask

  // Check results and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        check_result(out_rsp);
      if ((start && !busy) || out_strobe)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", stall_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Drive one request, wait for it to be taken, then advance the predictor
  task automatic send_request(input fcis_pkg::in_req_t req, input logic typed,
                              input fcis_pkg::out_rsp_t typed_rsp);
    fcis_pkg::out_rsp_t rsp;
    int                 a;
    int                 b;
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    useful_items++;
    a = int'(req.first_vertex);
    b = int'(req.second_vertex);
    if (req.command == fcis_pkg::CMD_ADD_EDGE) begin
      if (vertex_ok(req.first_vertex) && vertex_ok(req.second_vertex)) begin
        link_rows[a-1][b-1] = 1'b1;
        link_rows[b-1][a-1] = 1'b1;
        edges_stored++;
      end else begin
        edges_ignored++;
      end
    end else begin
      rsp = typed ? typed_rsp : search_graph();
      if (!rsp.found)
        misses_seen++;
      else if (rsp.set_kind == fcis_pkg::KIND_CLIQUE)
        cliques_seen++;
      else
        indeps_seen++;
      pending_sets.push_back(rsp);
      for (int v = 0; v < MAX_V; v++)
        link_rows[v] = '0;
    end
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Idle the sender now and then, never when quiet or in the closing stretch
  task automatic maybe_gap(input bit quiet);
    if (!quiet && useful_items < ITEM_TARGET * 9 / 10 && $urandom_range(0, 3) == 0)
      hold_off($urandom_range(1, 15));
  endtask

  // Drain all pending searches, let edge loads finish, then write the count
  task automatic set_count(input logic [VW-1:0] value);
    start <= 1'b0;
    do @(posedge clk); while (pending_sets.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    count_q = value;
  endtask

  task automatic send_link(input int a, input int b, input bit quiet);
    fcis_pkg::in_req_t req;
    req.command       = fcis_pkg::CMD_ADD_EDGE;
    req.first_vertex  = VW'(a);
    req.second_vertex = VW'(b);
    send_request(req, 1'b0, NOT_FOUND);
    maybe_gap(quiet);
  endtask

  task automatic plan_cfg(input int value);
    plan_row_t row;
    row.is_cfg    = 1'b1;
    row.cfg_value = VW'(value);
    row.req       = '0;
    row.typed     = 1'b0;
    row.rsp       = NOT_FOUND;
    directed_plan.push_back(row);
  endtask

  task automatic plan_req(input logic cmd, input int a, input int b, input logic typed,
                          input fcis_pkg::out_rsp_t rsp);
    plan_row_t row;
    row.is_cfg            = 1'b0;
    row.cfg_value         = '0;
    row.req.command       = cmd;
    row.req.first_vertex  = VW'(a);
    row.req.second_vertex = VW'(b);
    row.typed             = typed;
    row.rsp               = rsp;
    directed_plan.push_back(row);
  endtask

  initial begin
    int                mode;
    int                vc;
    int                span;
    int                n_edges;
    int                step;
    int                base;
    bit                quiet;
    fcis_pkg::in_req_t req;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    errors        = 0;
    stall_cycles  = 0;
    useful_items  = 0;
    edges_stored  = 0;
    edges_ignored = 0;
    cliques_seen  = 0;
    indeps_seen   = 0;
    misses_seen   = 0;
    count_q = fcis_pkg::VCOUNT_RESET;
    for (int v = 0; v < MAX_V; v++)
      link_rows[v] = '0;

    // Empty graph right after reset: the first five vertices are independent
    plan_req(fcis_pkg::CMD_SEARCH, 127, 127, 1'b1,
             make_set(fcis_pkg::KIND_INDEP, 1, 2, 3, 4, 5));
    // Too few vertices to hold a set
    plan_cfg(4);
    plan_req(fcis_pkg::CMD_SEARCH, 0, 0, 1'b1, NOT_FOUND);
    plan_cfg(0);
    plan_req(fcis_pkg::CMD_SEARCH, 64, 1, 1'b1, NOT_FOUND);
    // Self-loop, out-of-range endpoints and an edge past the count change nothing
    plan_cfg(5);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 64, 64, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 0, 3, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 3, 127, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 65, 2, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 1, 64, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_SEARCH, 0, 0, 1'b1,
             make_set(fcis_pkg::KIND_INDEP, 1, 2, 3, 4, 5));
    // Count above the maximum, clique on the top five vertices, one duplicate
    plan_cfg(127);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 60, 61, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 62, 60, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 60, 63, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 64, 60, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 61, 62, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 61, 63, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 64, 61, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 62, 63, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 62, 64, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 63, 64, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 61, 60, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_SEARCH, 0, 127, 1'b1,
             make_set(fcis_pkg::KIND_CLIQUE, 60, 61, 62, 63, 64));
    // Five vertices with one edge: neither a clique nor an independent set
    plan_cfg(5);
    plan_req(fcis_pkg::CMD_ADD_EDGE, 2, 4, 1'b0, NOT_FOUND);
    plan_req(fcis_pkg::CMD_SEARCH, 0, 0, 1'b1, NOT_FOUND);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        set_count(directed_plan[i].cfg_value);
      end else begin
        send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].rsp);
        maybe_gap(1'b0);
      end
    end

    // Random phases: set the count, load a graph, search
    while (useful_items < ITEM_TARGET) begin
      mode  = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      step  = 0;
      base  = 0;
      if (mode <= 5) begin
        vc      = $urandom_range(5, 10);
        span    = vc;
        n_edges = $urandom_range(0, vc * vc / 2);
      end else if (mode == 6) begin
        vc      = $urandom_range(0, 4);
        span    = MAX_V;
        n_edges = $urandom_range(0, 5);
      end else if (mode == 7) begin
        vc      = ($urandom_range(0, 1) == 0) ? MAX_V : $urandom_range(65, 127);
        span    = MAX_V;
        n_edges = $urandom_range(0, 12);
      end else if (mode == 8) begin
        vc      = MAX_V;
        span    = MAX_V;
        n_edges = $urandom_range(0, 6);
        step    = $urandom_range(1, 15);
        base    = $urandom_range(1, MAX_V - 4 * step);
      end else begin
        vc      = $urandom_range(11, 16);
        span    = vc;
        n_edges = $urandom_range(0, vc * vc / 2);
      end
      set_count(VW'(vc));

      // Plant a five-clique with evenly spaced members
      if (step != 0) begin
        for (int i = 0; i < 5; i++)
          for (int j = i + 1; j < 5; j++)
            if ($urandom_range(0, 1) == 0)
              send_link(base + i * step, base + j * step, quiet);
            else
              send_link(base + j * step, base + i * step, quiet);
      end

      // Mostly edges within the searched range, some noise anywhere
      repeat (n_edges) begin
        if ($urandom_range(0, 7) == 0)
          send_link($urandom_range(0, 127), $urandom_range(0, 127), quiet);
        else
          send_link($urandom_range(1, span), $urandom_range(1, span), quiet);
      end

      req.command       = fcis_pkg::CMD_SEARCH;
      req.first_vertex  = VW'($urandom_range(0, 127));
      req.second_vertex = VW'($urandom_range(0, 127));
      send_request(req, 1'b0, NOT_FOUND);
    end

    // Drain, then let the block settle
    start <= 1'b0;
    do @(posedge clk); while (pending_sets.size() != 0);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d stored and %0d ignored edge loads over vertex counts 0 to 127",
             edges_stored, edges_ignored);
    $display("searches gave %0d cliques, %0d independent sets, %0d with no set",
             cliques_seen, indeps_seen, misses_seen);
    if (errors == 0 && pending_sets.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
